[hdl/ibrm_pkg.sv]
// shared widths, constants and helper functions for the imu bias running mean
package ibrm_pkg;

   localparam int AXES          = 3;
   localparam int FRACTION_BITS = 16;

   localparam int SAMPLE_W  = 16;
   localparam int COUNT_W   = 32;
   localparam int GYRO_W    = 32;
   localparam int ACCEL_W   = 33;
   localparam int BIAS_W    = ACCEL_W;
   localparam int NUM_BIAS  = 6;
   localparam int AXIS_W    = 3;
   localparam int LANE_W    = 2;
   localparam int CSR_IDX_W = 2;

   localparam int TGT_W  = SAMPLE_W + 1 + FRACTION_BITS;
   localparam int MAG_W  = (TGT_W > BIAS_W) ? TGT_W : BIAS_W;
   localparam int CALC_W = MAG_W + 2;
   localparam int DIV_W  = CALC_W - 1;

   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_Z = 2'd2;

   localparam logic signed [SAMPLE_W-1:0] EXPECTED_X_RESET = 16'sd0;
   localparam logic signed [SAMPLE_W-1:0] EXPECTED_Y_RESET = 16'sd0;
   localparam logic signed [SAMPLE_W-1:0] EXPECTED_Z_RESET = 16'sd4096;

   localparam logic signed [CALC_W-1:0] GYRO_HI =
      {{(CALC_W-GYRO_W+1){1'b0}}, {(GYRO_W-1){1'b1}}};
   localparam logic signed [CALC_W-1:0] GYRO_LO = ~GYRO_HI;
   localparam logic signed [CALC_W-1:0] ACCEL_HI =
      {{(CALC_W-ACCEL_W+1){1'b0}}, {(ACCEL_W-1){1'b1}}};
   localparam logic signed [CALC_W-1:0] ACCEL_LO = ~ACCEL_HI;

   // sample (minus gravity for accel) scaled to fixed point
   function automatic logic signed [TGT_W-1:0] bias_target(
      input logic signed [SAMPLE_W-1:0] sample,
      input logic signed [SAMPLE_W-1:0] expected,
      input logic                       is_accel
   );
      logic signed [SAMPLE_W:0] d;
      d = {sample[SAMPLE_W-1], sample} -
          (is_accel ? {expected[SAMPLE_W-1], expected} : {(SAMPLE_W+1){1'b0}});
      return TGT_W'(d) <<< FRACTION_BITS;
   endfunction

   // clamp to the gyro or accel bias width
   function automatic logic signed [BIAS_W-1:0] sat_bias(
      input logic signed [CALC_W-1:0] v,
      input logic                     is_gyro
   );
      logic signed [CALC_W-1:0] hi;
      logic signed [CALC_W-1:0] lo;
      logic signed [CALC_W-1:0] r;
      hi = is_gyro ? GYRO_HI : ACCEL_HI;
      lo = is_gyro ? GYRO_LO : ACCEL_LO;
      if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end else begin
         r = v;
      end
      return BIAS_W'(r);
   endfunction

endpackage

[hdl/ibrm_div.sv]
// unsigned restoring divider, one quotient bit per cycle
module ibrm_div
   import ibrm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_W-1:0]   dividend,
   input  logic [COUNT_W-1:0] divisor,
   output logic               done,
   output logic [DIV_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [COUNT_W-1:0] dvs_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [COUNT_W:0]   shifted;
   logic [COUNT_W+1:0] trial;
   logic               fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      fits    = ~trial[COUNT_W+1];
      rem_in  = fits ? trial[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      quo_in  = {quo_ff[DIV_W-2:0], fits};
      cnt_in  = cnt_ff - CNT_W'(1);
      busy_in = busy_ff && (cnt_ff != CNT_W'(1));
      done_in = busy_ff && (cnt_ff == CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(DIV_W);
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         if (busy_ff) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hdl/imu_bias_running_mean_top.sv]
// imu bias running mean: six cumulative moving average biases, top level
//
// Each request carries one six-axis sample and its sample count. A count of
// zero seeds all biases from the sample (accel minus expected gravity); any
// other count moves each bias by (x - bias) / count, truncated toward zero,
// one axis after another through a single shared restoring divider that
// retires one quotient bit per cycle. Requests are not taken while one is in
// work. The six biases come back as one response per request, held in an
// output register so the next request can start while it waits.
// Expected gravity registers are written through the csr port; the user must
// write them only while idle, the block itself does not enforce it.
module imu_bias_running_mean_top
   import ibrm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [SAMPLE_W-1:0]        csr_wdata,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_gyro_x,
   input  logic signed [SAMPLE_W-1:0] req_gyro_y,
   input  logic signed [SAMPLE_W-1:0] req_gyro_z,
   input  logic signed [SAMPLE_W-1:0] req_accel_x,
   input  logic signed [SAMPLE_W-1:0] req_accel_y,
   input  logic signed [SAMPLE_W-1:0] req_accel_z,
   input  logic [COUNT_W-1:0]         req_sample_count,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [GYRO_W-1:0]   rsp_gyro_bias_x,
   output logic signed [GYRO_W-1:0]   rsp_gyro_bias_y,
   output logic signed [GYRO_W-1:0]   rsp_gyro_bias_z,
   output logic signed [ACCEL_W-1:0]  rsp_accel_bias_x,
   output logic signed [ACCEL_W-1:0]  rsp_accel_bias_y,
   output logic signed [ACCEL_W-1:0]  rsp_accel_bias_z
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   localparam logic [AXIS_W-1:0] LAST_AXIS  = AXIS_W'(NUM_BIAS - 1);
   localparam logic [AXIS_W-1:0] FIRST_ACC  = AXIS_W'(3);

   logic [1:0]                 state_ff;
   logic [AXIS_W-1:0]          axis_ff;
   logic signed [SAMPLE_W-1:0] sample_ff [NUM_BIAS];
   logic [COUNT_W-1:0]         count_ff;
   logic                       neg_ff;
   logic signed [BIAS_W-1:0]   bias_ff [NUM_BIAS];
   logic signed [BIAS_W-1:0]   out_ff [NUM_BIAS];
   logic signed [SAMPLE_W-1:0] exp_ff [3];
   logic                       rsp_valid_ff;

   logic                       is_gyro;
   logic [LANE_W-1:0]          lane;
   logic                       skip;
   logic signed [TGT_W-1:0]    target;
   logic signed [CALC_W-1:0]   diff;
   logic [CALC_W-1:0]          diff_abs;
   logic [DIV_W-1:0]           div_dividend;
   logic                       div_start;
   logic                       div_done;
   logic [DIV_W-1:0]           div_quotient;
   logic signed [CALC_W-1:0]   step;
   logic signed [CALC_W-1:0]   updated;
   logic                       last_axis;
   logic                       rsp_load;

   always_comb begin
      is_gyro      = axis_ff < FIRST_ACC;
      lane         = is_gyro ? axis_ff[LANE_W-1:0] : LANE_W'(axis_ff - FIRST_ACC);
      skip         = 32'(lane) >= AXES;
      target       = bias_target(sample_ff[axis_ff], exp_ff[lane], ~is_gyro);
      diff         = CALC_W'(target) - CALC_W'(bias_ff[axis_ff]);
      diff_abs     = diff[CALC_W-1] ? -diff : diff;
      div_dividend = diff_abs[DIV_W-1:0];
      div_start    = (state_ff == ST_SETUP) && !skip && (count_ff != '0);
      step         = neg_ff ? -$signed({1'b0, div_quotient})
                            : $signed({1'b0, div_quotient});
      updated      = CALC_W'(bias_ff[axis_ff]) + step;
      last_axis    = axis_ff == LAST_AXIS;
      rsp_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   ibrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // expected gravity registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff[0] <= EXPECTED_X_RESET;
         exp_ff[1] <= EXPECTED_Y_RESET;
         exp_ff[2] <= EXPECTED_Z_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_EXPECTED_X: exp_ff[0] <= csr_wdata;
            CSR_EXPECTED_Y: exp_ff[1] <= csr_wdata;
            CSR_EXPECTED_Z: exp_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer and bias store
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= '0;
         for (int i = 0; i < NUM_BIAS; i++) begin
            bias_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  axis_ff  <= '0;
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               if (skip || count_ff == '0) begin
                  if (!skip) begin
                     bias_ff[axis_ff] <= sat_bias(CALC_W'(target), is_gyro);
                  end
                  axis_ff  <= axis_ff + AXIS_W'(1);
                  state_ff <= last_axis ? ST_DONE : ST_SETUP;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  bias_ff[axis_ff] <= sat_bias(updated, is_gyro);
                  axis_ff          <= axis_ff + AXIS_W'(1);
                  state_ff         <= last_axis ? ST_DONE : ST_SETUP;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // request capture and divide sign
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff[0] <= req_gyro_x;
         sample_ff[1] <= req_gyro_y;
         sample_ff[2] <= req_gyro_z;
         sample_ff[3] <= req_accel_x;
         sample_ff[4] <= req_accel_y;
         sample_ff[5] <= req_accel_z;
         count_ff     <= req_sample_count;
      end
      if (div_start) begin
         neg_ff <= diff[CALC_W-1];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         for (int i = 0; i < NUM_BIAS; i++) begin
            out_ff[i] <= bias_ff[i];
         end
      end
   end

   assign csr_ready        = !reset;
   assign req_ready        = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gyro_bias_x  = out_ff[0][GYRO_W-1:0];
   assign rsp_gyro_bias_y  = out_ff[1][GYRO_W-1:0];
   assign rsp_gyro_bias_z  = out_ff[2][GYRO_W-1:0];
   assign rsp_accel_bias_x = out_ff[3];
   assign rsp_accel_bias_y = out_ff[4];
   assign rsp_accel_bias_z = out_ff[5];

endmodule
